FILE: hw/rtl/snps_pkg.sv
// Shared types and constants for the short name parser with Shift-JIS handling.
`default_nettype none
package snps_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [BYTE_W-1:0] LEAD_LO_A = 8'h81;
  localparam logic [BYTE_W-1:0] LEAD_HI_A = 8'h9F;
  localparam logic [BYTE_W-1:0] LEAD_LO_B = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_HI_B = 8'hFC;
  localparam logic [BYTE_W-1:0] CHAR_DOT = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              zero;
    logic              dot;
    logic              lead;
  } item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/snps_front.sv
// Front end: classifies each incoming name byte before it is queued.
`default_nettype none
module snps_front (
  input  wire logic [snps_pkg::BYTE_W-1:0] in_byte,
  output snps_pkg::item_t                  item
);

  logic lead_a;
  logic lead_b;

  assign lead_a = (in_byte >= snps_pkg::LEAD_LO_A) && (in_byte <= snps_pkg::LEAD_HI_A);
  assign lead_b = (in_byte >= snps_pkg::LEAD_LO_B) && (in_byte <= snps_pkg::LEAD_HI_B);

  assign item.data = in_byte;
  assign item.zero = (in_byte == snps_pkg::CHAR_NUL);
  assign item.dot  = (in_byte == snps_pkg::CHAR_DOT);
  assign item.lead = lead_a || lead_b;

endmodule
`default_nettype wire

FILE: hw/rtl/snps_queue.sv
// Short queue of classified bytes between the front and back ends.
`default_nettype none
module snps_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire snps_pkg::item_t wr_item,
  output logic                 full,
  input  wire logic            pop,
  output snps_pkg::item_t      rd_item,
  output logic                 empty
);

  localparam int PW = $clog2(snps_pkg::QUEUE_DEPTH);
  localparam logic [PW:0] DEPTH_C = (PW+1)'(snps_pkg::QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(snps_pkg::QUEUE_DEPTH - 1);

  snps_pkg::item_t mem_r [snps_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == DEPTH_C);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/snps_back.sv
// Back end: parse state machine, name and extension stores, padded result drain.
`default_nettype none
module snps_back #(
  parameter int NAME_LEN = 8,
  parameter int EXT_LEN  = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire snps_pkg::item_t             q_item,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  output logic [snps_pkg::BYTE_W-1:0]      out_byte,
  output logic [snps_pkg::POS_W-1:0]       out_position,
  output logic                             out_ok,
  output logic                             out_last,
  output logic                             empty,
  input  wire logic                        pop
);

  localparam int TOTAL = NAME_LEN + EXT_LEN;
  localparam int KW = $clog2(TOTAL);
  localparam int MAXL = (NAME_LEN > EXT_LEN) ? NAME_LEN : EXT_LEN;
  localparam int FW = $clog2(MAXL + 3);
  localparam logic [FW-1:0] NAME_L = FW'(NAME_LEN);
  localparam logic [FW-1:0] EXT_L = FW'(EXT_LEN);
  localparam logic [FW-1:0] TWO = FW'(2);
  localparam logic [KW-1:0] K_LAST = KW'(TOTAL - 1);

  typedef enum logic [2:0] {
    PH_START, PH_DOT1, PH_DOT2, PH_BASE, PH_EXT, PH_BAD, PH_EMIT
  } phase_t;

  phase_t phase_r;
  logic [FW-1:0]                 fill_r;
  logic                          lead_pending_r;
  logic [snps_pkg::BYTE_W-1:0]   lead_value_r;
  logic                          lead_fits_r;
  logic                          bad_r;
  logic [snps_pkg::BYTE_W-1:0]   name_r [NAME_LEN];
  logic [snps_pkg::BYTE_W-1:0]   ext_r [EXT_LEN];
  logic [KW-1:0]                 k_r;
  logic                          out_valid_r;
  logic [snps_pkg::BYTE_W-1:0]   out_byte_r;
  logic [snps_pkg::POS_W-1:0]    out_pos_r;
  logic                          out_ok_r;
  logic                          out_last_r;

  logic                          take;
  logic                          step;
  logic [FW-1:0]                 field_len;
  logic [FW-1:0]                 fill_p1;
  logic                          fits1;
  logic                          fits2;
  logic                          start_dot;
  logic                          dot1_dot;
  logic                          go_bad;
  logic                          char_ph;
  logic                          trail;
  logic                          to_ext;
  logic                          new_lead;
  logic                          plain_wr;
  logic                          pair_wr;
  logic                          wr_ext;
  logic                          emit_ld;
  logic                          emit_last;
  logic [snps_pkg::BYTE_W-1:0]   rd_byte;

  assign take      = (phase_r != PH_EMIT) && !q_empty;
  assign q_pop     = take;
  assign step      = take && !q_item.zero;
  assign wr_ext    = (phase_r == PH_EXT);
  assign field_len = wr_ext ? EXT_L : NAME_L;
  assign fill_p1   = fill_r + 1'b1;
  assign fits1     = fill_r < field_len;
  assign fits2     = (fill_r + TWO) <= field_len;

  assign start_dot = step && (phase_r == PH_START) && q_item.dot;
  assign dot1_dot  = step && (phase_r == PH_DOT1) && q_item.dot;
  assign go_bad    = step && (((phase_r == PH_DOT1) && !q_item.dot) || (phase_r == PH_DOT2));
  assign char_ph   = step && (((phase_r == PH_START) && !q_item.dot) ||
                              (phase_r == PH_BASE) || (phase_r == PH_EXT));
  assign trail     = char_ph && lead_pending_r;
  assign to_ext    = char_ph && !lead_pending_r && (phase_r == PH_BASE) && q_item.dot;
  assign new_lead  = char_ph && !lead_pending_r && !to_ext && q_item.lead;
  assign plain_wr  = char_ph && !lead_pending_r && !to_ext && !q_item.lead && fits1;
  assign pair_wr   = trail && lead_fits_r && fits2;

  assign emit_ld   = (phase_r == PH_EMIT) && (!out_valid_r || pop);
  assign emit_last = (k_r == K_LAST);

  always_comb begin
    rd_byte = snps_pkg::CHAR_SPACE;
    for (int i = 0; i < NAME_LEN; i++) begin
      if (k_r == KW'(i)) rd_byte = name_r[i];
    end
    for (int j = 0; j < EXT_LEN; j++) begin
      if (k_r == KW'(NAME_LEN + j)) rd_byte = ext_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_START;
      fill_r         <= '0;
      lead_pending_r <= 1'b0;
      lead_value_r   <= '0;
      lead_fits_r    <= 1'b0;
      bad_r          <= 1'b0;
      k_r            <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < NAME_LEN; i++) name_r[i] <= snps_pkg::CHAR_SPACE;
      for (int j = 0; j < EXT_LEN; j++) ext_r[j] <= snps_pkg::CHAR_SPACE;
    end else begin
      if (pop && out_valid_r && !emit_ld) begin
        out_valid_r <= 1'b0;
      end

      if (take && q_item.zero) begin
        phase_r <= PH_EMIT;
        k_r     <= '0;
      end
      if (start_dot) phase_r <= PH_DOT1;
      if (dot1_dot) phase_r <= PH_DOT2;
      if (go_bad) begin
        phase_r <= PH_BAD;
        bad_r   <= 1'b1;
      end
      if (char_ph && (phase_r == PH_START)) phase_r <= PH_BASE;
      if (to_ext) begin
        phase_r <= PH_EXT;
        fill_r  <= '0;
      end
      if (new_lead) begin
        lead_pending_r <= 1'b1;
        lead_value_r   <= q_item.data;
        lead_fits_r    <= fits2;
      end
      if (trail) begin
        lead_pending_r <= 1'b0;
        lead_fits_r    <= 1'b0;
        lead_value_r   <= '0;
      end
      if (plain_wr) fill_r <= fill_p1;
      if (pair_wr) fill_r <= fill_r + TWO;

      for (int i = 0; i < NAME_LEN; i++) begin
        if (!wr_ext && plain_wr && (fill_r == FW'(i))) name_r[i] <= q_item.data;
        if (!wr_ext && pair_wr && (fill_r == FW'(i))) name_r[i] <= lead_value_r;
        if (!wr_ext && pair_wr && (fill_p1 == FW'(i))) name_r[i] <= q_item.data;
      end
      for (int j = 0; j < EXT_LEN; j++) begin
        if (wr_ext && plain_wr && (fill_r == FW'(j))) ext_r[j] <= q_item.data;
        if (wr_ext && pair_wr && (fill_r == FW'(j))) ext_r[j] <= lead_value_r;
        if (wr_ext && pair_wr && (fill_p1 == FW'(j))) ext_r[j] <= q_item.data;
      end
      if (start_dot) name_r[0] <= snps_pkg::CHAR_DOT;
      if (dot1_dot) name_r[1] <= snps_pkg::CHAR_DOT;

      if (emit_ld) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= rd_byte;
        out_pos_r   <= snps_pkg::POS_W'(k_r);
        out_ok_r    <= !bad_r;
        out_last_r  <= emit_last;
        if (emit_last) begin
          phase_r        <= PH_START;
          k_r            <= '0;
          fill_r         <= '0;
          lead_pending_r <= 1'b0;
          lead_value_r   <= '0;
          lead_fits_r    <= 1'b0;
          bad_r          <= 1'b0;
          for (int i = 0; i < NAME_LEN; i++) name_r[i] <= snps_pkg::CHAR_SPACE;
          for (int j = 0; j < EXT_LEN; j++) ext_r[j] <= snps_pkg::CHAR_SPACE;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
    end
  end

  assign empty        = !out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_position = out_pos_r;
  assign out_ok       = out_ok_r;
  assign out_last     = out_last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/short_name_parser_sjis_unit.sv
// Short (8.3) file name parser with Shift-JIS lead byte handling, top level.
// Bytes of a name are pushed one per cycle while full is low; a zero byte ends
// the name. Each byte is classified on entry and waits in a four-entry queue;
// outside a drain the parse engine consumes one byte per cycle, so a steady
// stream of name bytes is accepted at one per clock. A zero byte makes the
// engine drain the padded name through the result register, one transaction
// per cycle while pop keeps up, NAME_LEN + EXT_LEN in all (position
// 0..NAME_LEN-1 base, then extension, last set on the final one, ok cleared
// for a dot-led name other than "." or ".."). While that drain runs the engine
// takes no bytes, so the queue absorbs up to four more before full rises. A
// popped zero byte sets the emit phase, and that phase loads the first result.
`default_nettype none
module short_name_parser_sjis_unit #(
  parameter int NAME_LEN = 8,
  parameter int EXT_LEN  = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [snps_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                        push,
  output logic                             full,
  output logic [snps_pkg::BYTE_W-1:0]      out_byte,
  output logic [snps_pkg::POS_W-1:0]       out_position,
  output logic                             out_ok,
  output logic                             out_last,
  output logic                             empty,
  input  wire logic                        pop
);

  snps_pkg::item_t wr_item;
  snps_pkg::item_t rd_item;
  logic            q_empty;
  logic            q_pop;

  snps_front u_front (
    .in_byte (in_byte),
    .item    (wr_item)
  );

  snps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .full    (full),
    .pop     (q_pop),
    .rd_item (rd_item),
    .empty   (q_empty)
  );

  snps_back #(
    .NAME_LEN (NAME_LEN),
    .EXT_LEN  (EXT_LEN)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_item       (rd_item),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_byte     (out_byte),
    .out_position (out_position),
    .out_ok       (out_ok),
    .out_last     (out_last),
    .empty        (empty),
    .pop          (pop)
  );

`ifndef SYNTHESIS
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last) |-> (out_position == snps_pkg::POS_W'(NAME_LEN + EXT_LEN - 1)))
    else $error("last transaction not at final position");

  a_ok_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last) |=> (empty || (out_ok == $past(out_ok))))
    else $error("ok flag changed within one name");

  a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_last) |=> (empty || (out_position == '0)))
    else $error("new name does not start at position zero");
`endif

endmodule
`default_nettype wire
